FILE: rtl/mqef_pkg.sv
// ----------------------------------------------------------------------------
// mqef_pkg
// Shared types and constants for the multi-queue event FIFO with wake gate.
// ----------------------------------------------------------------------------
package mqef_pkg;

    // Width of the event word ports
    localparam int WORD_W = 64;

    // Entries in the command queue between front and back
    localparam int CMDQ_DEPTH = 4;

    // Request codes on the input channel
    typedef enum logic [1:0] {
        REQ_PUSH      = 2'd0,
        REQ_POP       = 2'd1,
        REQ_REARM     = 2'd2,
        REQ_DEV_RESET = 2'd3
    } t_req_type;

    // Memory operation that the back end performs for one request
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } t_mem_op;

    // Result flags settled by the front end
    typedef struct packed {
        logic success;
        logic wake_request;
        logic gate_state;
    } t_res_flags;

endpackage

FILE: rtl/mqef_front.sv
// ----------------------------------------------------------------------------
// mqef_front
// Accepts requests, keeps the ring pointers and the wake gate, and turns each
// request into a memory command plus its result flags.
// ----------------------------------------------------------------------------
module mqef_front #(
    parameter int QUEUE_DEPTH  = 1024,
    parameter int DEVICE_COUNT = 2,
    parameter int ENTRY_WIDTH  = 64,
    parameter int ADDR_W       = 11
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_req_type,
    input  logic                        i_device_sel,
    input  logic [mqef_pkg::WORD_W-1:0] i_entry_data,
    output logic                        o_cmd_valid,
    input  logic                        i_cmd_ready,
    output mqef_pkg::t_mem_op           o_cmd_op,
    output logic [ADDR_W-1:0]           o_cmd_addr,
    output logic [ENTRY_WIDTH-1:0]      o_cmd_data,
    output mqef_pkg::t_res_flags        o_cmd_flags
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int DEV_W = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;

    logic [PTR_W-1:0] r_wp [DEVICE_COUNT];
    logic [PTR_W-1:0] r_rp [DEVICE_COUNT];
    logic [PTR_W-1:0] n_wp [DEVICE_COUNT];
    logic [PTR_W-1:0] n_rp [DEVICE_COUNT];
    logic             r_gate;
    logic             n_gate;

    logic                    accept;
    logic                    dev_ok;
    logic [DEV_W-1:0]        dev_idx;
    logic [PTR_W-1:0]        wp;
    logic [PTR_W-1:0]        rp;
    logic [PTR_W-1:0]        wp_next;
    logic [DEVICE_COUNT-1:0] busy;
    logic [DEVICE_COUNT-1:0] sel_mask;
    logic                    any_busy;
    logic                    others_busy;
    logic [ADDR_W-1:0]       base;
    mqef_pkg::t_req_type     req;

    // Ring pointer step with wrap at the last slot
    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    assign o_ready     = i_cmd_ready;
    assign accept      = i_valid && i_cmd_ready;
    assign o_cmd_valid = accept;
    assign o_cmd_data  = i_entry_data[ENTRY_WIDTH-1:0];
    assign req         = mqef_pkg::t_req_type'(i_req_type);

    // Queue selection and occupancy
    always_comb begin
        dev_ok  = int'(i_device_sel) < DEVICE_COUNT;
        dev_idx = dev_ok ? DEV_W'(i_device_sel) : '0;
        wp      = r_wp[dev_idx];
        rp      = r_rp[dev_idx];
        wp_next = advance(wp);
        for (int d = 0; d < DEVICE_COUNT; d++) begin
            busy[d]     = r_wp[d] != r_rp[d];
            sel_mask[d] = DEV_W'(d) == dev_idx;
        end
        any_busy    = |busy;
        others_busy = |(busy & ~sel_mask);
        base        = ADDR_W'(dev_idx) * ADDR_W'(QUEUE_DEPTH);
    end

    // Request decode and next state
    always_comb begin
        n_wp       = r_wp;
        n_rp       = r_rp;
        n_gate     = r_gate;
        o_cmd_op   = mqef_pkg::OP_NONE;
        o_cmd_addr = base + ADDR_W'(wp);
        o_cmd_flags.success      = 1'b0;
        o_cmd_flags.wake_request = 1'b0;
        if (accept) begin
            unique case (req)
                mqef_pkg::REQ_PUSH: begin
                    if (dev_ok && wp_next != rp) begin
                        n_wp[dev_idx]       = wp_next;
                        o_cmd_op            = mqef_pkg::OP_WRITE;
                        o_cmd_flags.success = 1'b1;
                        if (!r_gate) begin
                            n_gate                   = 1'b1;
                            o_cmd_flags.wake_request = 1'b1;
                        end
                    end
                end
                mqef_pkg::REQ_POP: begin
                    if (dev_ok && wp != rp) begin
                        n_rp[dev_idx]       = advance(rp);
                        o_cmd_op            = mqef_pkg::OP_READ;
                        o_cmd_addr          = base + ADDR_W'(rp);
                        o_cmd_flags.success = 1'b1;
                    end
                end
                mqef_pkg::REQ_REARM: begin
                    n_gate              = 1'b0;
                    o_cmd_flags.success = !any_busy;
                end
                mqef_pkg::REQ_DEV_RESET: begin
                    if (dev_ok) begin
                        // flush, then set the gate and wake if another queue still has work
                        n_rp[dev_idx]            = wp;
                        n_gate                   = others_busy;
                        o_cmd_flags.wake_request = others_busy;
                    end
                end
            endcase
        end
        o_cmd_flags.gate_state = n_gate;
    end

    // Pointer and gate registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < DEVICE_COUNT; d++) begin
                r_wp[d] <= '0;
                r_rp[d] <= '0;
            end
            r_gate <= 1'b0;
        end else begin
            r_wp   <= n_wp;
            r_rp   <= n_rp;
            r_gate <= n_gate;
        end
    end

endmodule

FILE: rtl/mqef_cmdq.sv
// ----------------------------------------------------------------------------
// mqef_cmdq
// Short command FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module mqef_cmdq #(
    parameter int WIDTH = 80
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    localparam int DEPTH = mqef_pkg::CMDQ_DEPTH;
    localparam int PW    = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [PW:0]      r_cnt;
    logic             push;
    logic             pop;

    assign o_ready = r_cnt != (PW + 1)'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop)  r_rd <= r_rd + 1'b1;
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= i_data;
    end

endmodule

FILE: rtl/mqef_back.sv
// ----------------------------------------------------------------------------
// mqef_back
// Carries out the memory command of each request against the entry store and
// holds the finished result in an output register.
// ----------------------------------------------------------------------------
module mqef_back #(
    parameter int ENTRY_WIDTH = 64,
    parameter int ADDR_W      = 11,
    parameter int MEM_DEPTH   = 2048
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_valid,
    output logic                        o_cmd_ready,
    input  mqef_pkg::t_mem_op           i_cmd_op,
    input  logic [ADDR_W-1:0]           i_cmd_addr,
    input  logic [ENTRY_WIDTH-1:0]      i_cmd_data,
    input  mqef_pkg::t_res_flags        i_cmd_flags,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_success,
    output logic [mqef_pkg::WORD_W-1:0] o_entry_out,
    output logic                        o_wake_request,
    output logic                        o_gate_state
);

    logic [ENTRY_WIDTH-1:0] r_mem [MEM_DEPTH];
    logic [ENTRY_WIDTH-1:0] r_rd_data;
    logic                   r_s1_valid;
    mqef_pkg::t_mem_op      r_s1_op;
    mqef_pkg::t_res_flags   r_s1_flags;
    logic                   r_out_valid;
    logic [ENTRY_WIDTH-1:0] r_out_data;
    mqef_pkg::t_res_flags   r_out_flags;
    logic                   take;
    logic                   s1_move;

    assign s1_move     = r_s1_valid && (!r_out_valid || i_ready);
    assign o_cmd_ready = !r_s1_valid || s1_move;
    assign take        = i_cmd_valid && o_cmd_ready;

    assign o_valid        = r_out_valid;
    assign o_success      = r_out_flags.success;
    assign o_wake_request = r_out_flags.wake_request;
    assign o_gate_state   = r_out_flags.gate_state;
    assign o_entry_out    = mqef_pkg::WORD_W'(r_out_data);

    // Entry store: one access per cycle while commands are taken, read data registered
    always_ff @(posedge i_clk) begin
        if (take && i_cmd_op == mqef_pkg::OP_WRITE) r_mem[i_cmd_addr] <= i_cmd_data;
        if (take && i_cmd_op == mqef_pkg::OP_READ)  r_rd_data <= r_mem[i_cmd_addr];
    end

    // Stage and output valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Stage and output payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_op    <= i_cmd_op;
            r_s1_flags <= i_cmd_flags;
        end
        if (s1_move) begin
            r_out_flags <= r_s1_flags;
            r_out_data  <= (r_s1_op == mqef_pkg::OP_READ) ? r_rd_data : '0;
        end
    end

endmodule

FILE: rtl/multi_queue_event_fifo_with_wake_gate.sv
// ----------------------------------------------------------------------------
// multi_queue_event_fifo_with_wake_gate
// One ring FIFO per device with a shared wake gate, split into a front end,
// a command queue and a back end around the entry store.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on i_valid/o_ready with i_req_type (push, pop, rearm,
//   device reset), i_device_sel and i_entry_data. Every request gives exactly
//   one result on o_valid/i_ready: o_success, o_entry_out, o_wake_request
//   and o_gate_state.
//   Throughput: one request per cycle while the command queue has room.
//   The front end settles pointers and the gate in the cycle of acceptance;
//   the back end performs one store access per cycle on the single-port
//   entry memory. A result passes through the command queue, the memory
//   read stage and then the output register.
//   Each queue holds up to QUEUE_DEPTH-1 entries; a full push is dropped.
//   Reset clears the pointers, the gate and all valid flags; the entry store
//   is not cleared and needs no sweep, so requests are taken right away.
//   When the receiver stalls, results back up through the output register,
//   the memory stage and a four-deep command queue, then o_ready drops.
// ----------------------------------------------------------------------------
module multi_queue_event_fifo_with_wake_gate #(
    parameter int QUEUE_DEPTH  = 1024,
    parameter int DEVICE_COUNT = 2,
    parameter int ENTRY_WIDTH  = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_req_type,
    input  logic                        i_device_sel,
    input  logic [mqef_pkg::WORD_W-1:0] i_entry_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_success,
    output logic [mqef_pkg::WORD_W-1:0] o_entry_out,
    output logic                        o_wake_request,
    output logic                        o_gate_state
);

    localparam int MEM_DEPTH = DEVICE_COUNT * QUEUE_DEPTH;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int OP_W      = $bits(mqef_pkg::t_mem_op);
    localparam int FLAG_W    = $bits(mqef_pkg::t_res_flags);
    localparam int CMD_W     = OP_W + ADDR_W + ENTRY_WIDTH + FLAG_W;

    logic                   f_valid;
    logic                   f_ready;
    mqef_pkg::t_mem_op      f_op;
    logic [ADDR_W-1:0]      f_addr;
    logic [ENTRY_WIDTH-1:0] f_data;
    mqef_pkg::t_res_flags   f_flags;

    logic                   b_valid;
    logic                   b_ready;
    logic [CMD_W-1:0]       q_in;
    logic [CMD_W-1:0]       q_out;
    logic [OP_W-1:0]        b_op_bits;
    logic [ADDR_W-1:0]      b_addr;
    logic [ENTRY_WIDTH-1:0] b_data;
    logic [FLAG_W-1:0]      b_flag_bits;

    // Front end: decode, pointers, wake gate
    mqef_front #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .DEVICE_COUNT (DEVICE_COUNT),
        .ENTRY_WIDTH  (ENTRY_WIDTH),
        .ADDR_W       (ADDR_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_req_type   (i_req_type),
        .i_device_sel (i_device_sel),
        .i_entry_data (i_entry_data),
        .o_cmd_valid  (f_valid),
        .i_cmd_ready  (f_ready),
        .o_cmd_op     (f_op),
        .o_cmd_addr   (f_addr),
        .o_cmd_data   (f_data),
        .o_cmd_flags  (f_flags)
    );

    assign q_in = {f_op, f_addr, f_data, f_flags};

    // Command queue between the two halves
    mqef_cmdq #(
        .WIDTH   (CMD_W)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (q_in),
        .o_valid (b_valid),
        .i_ready (b_ready),
        .o_data  (q_out)
    );

    assign {b_op_bits, b_addr, b_data, b_flag_bits} = q_out;

    // Back end: entry store and result register
    mqef_back #(
        .ENTRY_WIDTH    (ENTRY_WIDTH),
        .ADDR_W         (ADDR_W),
        .MEM_DEPTH      (MEM_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (b_valid),
        .o_cmd_ready    (b_ready),
        .i_cmd_op       (mqef_pkg::t_mem_op'(b_op_bits)),
        .i_cmd_addr     (b_addr),
        .i_cmd_data     (b_data),
        .i_cmd_flags    (mqef_pkg::t_res_flags'(b_flag_bits)),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_success      (o_success),
        .o_entry_out    (o_entry_out),
        .o_wake_request (o_wake_request),
        .o_gate_state   (o_gate_state)
    );

    // A wake request always leaves the gate set
    a_wake_sets_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_wake_request |-> o_gate_state)
        else $error("wake request without pending gate");

    // Only a successful pop carries a nonzero word
    a_data_needs_success: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_entry_out != '0) |-> o_success && !o_wake_request)
        else $error("entry word on a result that is not a pop");

    // No result straight out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

FILE: test/event_fifo_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_fifo_checker
// Watches the request and result channels of the multi-queue event FIFO,
// keeps its own copy of the device rings and the wake gate, works out the
// result of every accepted request and compares it with what comes out.
// ----------------------------------------------------------------------------
module event_fifo_checker #(
    parameter int QUEUE_DEPTH  = 1024,
    parameter int DEVICE_COUNT = 2,
    parameter int ENTRY_WIDTH  = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    input  logic                        i_req_ready,
    input  logic [1:0]                  i_req_type,
    input  logic                        i_req_device,
    input  logic [mqef_pkg::WORD_W-1:0] i_req_data,
    input  logic                        i_res_valid,
    input  logic                        i_res_ready,
    input  logic                        i_res_success,
    input  logic [mqef_pkg::WORD_W-1:0] i_res_entry,
    input  logic                        i_res_wake,
    input  logic                        i_res_pending,
    output int                          o_fail_count,
    output int                          o_due_count
);

    localparam logic [mqef_pkg::WORD_W-1:0] STORED_MASK =
        {mqef_pkg::WORD_W{1'b1}} >> (mqef_pkg::WORD_W - ENTRY_WIDTH);

    typedef struct {
        logic                        success;
        logic [mqef_pkg::WORD_W-1:0] entry;
        logic                        wake;
        logic                        gate;
    } t_fifo_outcome;

    // Shadow of the device rings and the shared wake gate
    logic [mqef_pkg::WORD_W-1:0] ring_words [DEVICE_COUNT][QUEUE_DEPTH];
    int unsigned                 wr_slot    [DEVICE_COUNT];
    int unsigned                 rd_slot    [DEVICE_COUNT];
    logic                        gate_set;

    t_fifo_outcome     due_results [$];
    int                misfits;
    int                results_seen;

    function automatic int unsigned next_slot(int unsigned slot);
        return (slot + 1 >= QUEUE_DEPTH) ? 0 : slot + 1;
    endfunction

    function automatic logic rings_drained();
        for (int d = 0; d < DEVICE_COUNT; d++) begin
            if (wr_slot[d] != rd_slot[d]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Apply one request to the shadow state and return the result it gives
    function automatic t_fifo_outcome apply_request(mqef_pkg::t_req_type kind,
                                                    int unsigned dev,
                                                    logic [mqef_pkg::WORD_W-1:0] data);
        t_fifo_outcome res;
        int unsigned   nxt;
        res = '{success: 1'b0, entry: '0, wake: 1'b0, gate: 1'b0};
        if (kind == mqef_pkg::REQ_REARM) begin
            gate_set    = 1'b0;
            res.success = rings_drained();
        end else if (dev < DEVICE_COUNT) begin
            case (kind)
                mqef_pkg::REQ_PUSH: begin
                    nxt = next_slot(wr_slot[dev]);
                    // full ring drops the new word
                    if (nxt != rd_slot[dev]) begin
                        ring_words[dev][wr_slot[dev]] = data & STORED_MASK;
                        wr_slot[dev] = nxt;
                        res.success  = 1'b1;
                        if (!gate_set) begin
                            gate_set = 1'b1;
                            res.wake = 1'b1;
                        end
                    end
                end
                mqef_pkg::REQ_POP: begin
                    if (wr_slot[dev] != rd_slot[dev]) begin
                        res.entry    = ring_words[dev][rd_slot[dev]];
                        rd_slot[dev] = next_slot(rd_slot[dev]);
                        res.success  = 1'b1;
                    end
                end
                default: begin
                    // flush, then wake again if another ring still holds words
                    rd_slot[dev] = wr_slot[dev];
                    gate_set     = 1'b0;
                    if (!rings_drained()) begin
                        gate_set = 1'b1;
                        res.wake = 1'b1;
                    end
                end
            endcase
        end
        res.gate = gate_set;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_fifo_outcome want;
        if (!i_rst_n) begin
            for (int d = 0; d < DEVICE_COUNT; d++) begin
                wr_slot[d] = 0;
                rd_slot[d] = 0;
            end
            gate_set = 1'b0;
            due_results.delete();
            misfits      = 0;
            results_seen = 0;
        end else begin
            // result side: compare with the oldest expectation
            if (i_res_valid && i_res_ready) begin
                if (due_results.size() == 0) begin
                    misfits++;
                    if (misfits <= 10)
                        $display("result %0d arrived with no request outstanding",
                                 results_seen);
                end else begin
                    want = due_results.pop_front();
                    if (want.success !== i_res_success || want.entry !== i_res_entry ||
                        want.wake !== i_res_wake || want.gate !== i_res_pending) begin
                        misfits++;
                        if (misfits <= 10)
                            $display("result %0d: exp ok=%0b word=%h wake=%0b gate=%0b,",
                                     results_seen, want.success, want.entry, want.wake,
                                     want.gate,
                                     " got ok=%0b word=%h wake=%0b gate=%0b",
                                     i_res_success, i_res_entry, i_res_wake, i_res_pending);
                    end
                end
                results_seen++;
            end
            // request side: predict the result
            if (i_req_valid && i_req_ready)
                due_results.push_back(apply_request(mqef_pkg::t_req_type'(i_req_type),
                                                    i_req_device, i_req_data));
        end
        o_due_count  <= due_results.size();
        o_fail_count <= misfits;
    end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives push, pop, rearm and device reset requests into the multi-queue
// event FIFO: a directed opening, one ring filled past full, a drain, then
// random mixes with bursts of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int QUEUE_DEPTH  = 1024;
    localparam int DEVICE_COUNT = 2;
    localparam int ENTRY_WIDTH  = 64;
    localparam int CYCLE_LIMIT  = 400000;

    logic                        i_clk        = 1'b0;
    logic                        i_rst_n      = 1'b0;
    logic                        i_valid      = 1'b0;
    logic [1:0]                  i_req_type   = mqef_pkg::REQ_PUSH;
    logic                        i_device_sel = 1'b0;
    logic [mqef_pkg::WORD_W-1:0] i_entry_data = '0;
    logic                        i_ready      = 1'b0;
    logic                        o_ready;
    logic                        o_valid;
    logic                        o_success;
    logic [mqef_pkg::WORD_W-1:0] o_entry_out;
    logic                        o_wake_request;
    logic                        o_gate_state;

    logic              idle_on      = 1'b1;
    int                stall_left   = 0;
    int                cycle_count  = 0;
    int                n_sent       = 0;
    int                fail_count;
    int                due_count;

    multi_queue_event_fifo_with_wake_gate #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .DEVICE_COUNT (DEVICE_COUNT),
        .ENTRY_WIDTH  (ENTRY_WIDTH)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req_type     (i_req_type),
        .i_device_sel   (i_device_sel),
        .i_entry_data   (i_entry_data),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_success      (o_success),
        .o_entry_out    (o_entry_out),
        .o_wake_request (o_wake_request),
        .o_gate_state   (o_gate_state)
    );

    event_fifo_checker #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .DEVICE_COUNT (DEVICE_COUNT),
        .ENTRY_WIDTH  (ENTRY_WIDTH)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .i_req_ready   (o_ready),
        .i_req_type    (i_req_type),
        .i_req_device  (i_device_sel),
        .i_req_data    (i_entry_data),
        .i_res_valid   (o_valid),
        .i_res_ready   (i_ready),
        .i_res_success (o_success),
        .i_res_entry   (o_entry_out),
        .i_res_wake    (o_wake_request),
        .i_res_pending (o_gate_state),
        .o_fail_count  (fail_count),
        .o_due_count   (due_count)
    );

    always #6 i_clk = ~i_clk;

    // Receiver stalls in bursts while idling is on
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready    <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(1, 19) - 1;
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("multi_queue_event_fifo_with_wake_gate test failed");
            $finish;
        end
    end

    function automatic logic [mqef_pkg::WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Present one request, with an optional gap first, and wait until taken
    task automatic issue(input mqef_pkg::t_req_type kind, input logic dev,
                         input logic [mqef_pkg::WORD_W-1:0] word);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 19);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_req_type   <= kind;
        i_device_sel <= dev;
        i_entry_data <= word;
        do @(posedge i_clk); while (!o_ready);
        n_sent++;
    endtask

    // Random segments with their own mix of request kinds
    task automatic run_mix(input int stop_at, input logic allow_idle);
        int w_push, w_pop, w_rearm, w_reset, seg_len, pick;
        while (n_sent < stop_at) begin
            w_push  = $urandom_range(1, 10);
            w_pop   = $urandom_range(1, 10);
            w_rearm = $urandom_range(0, 3);
            w_reset = $urandom_range(0, 1);
            seg_len = $urandom_range(20, 80);
            idle_on <= allow_idle && ($urandom_range(0, 3) != 0);
            for (int k = 0; k < seg_len && n_sent < stop_at; k++) begin
                pick = $urandom_range(0, w_push + w_pop + w_rearm + w_reset - 1);
                if (pick < w_push)
                    issue(mqef_pkg::REQ_PUSH, 1'($urandom_range(0, 1)), rand_word());
                else if (pick < w_push + w_pop)
                    issue(mqef_pkg::REQ_POP, 1'($urandom_range(0, 1)), rand_word());
                else if (pick < w_push + w_pop + w_rearm)
                    issue(mqef_pkg::REQ_REARM, 1'($urandom_range(0, 1)), rand_word());
                else
                    issue(mqef_pkg::REQ_DEV_RESET, 1'($urandom_range(0, 1)), rand_word());
            end
        end
    endtask

    initial begin
        logic dev;
        int   pushed;
        int   pick;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty pops, rearm on empty, gate set and already set,
        // rearm with words held, device reset with and without other words
        issue(mqef_pkg::REQ_POP,       1'b0, '0);
        issue(mqef_pkg::REQ_POP,       1'b1, '0);
        issue(mqef_pkg::REQ_REARM,     1'b0, '0);
        issue(mqef_pkg::REQ_PUSH,      1'b0, '0);
        issue(mqef_pkg::REQ_PUSH,      1'b0, '1);
        issue(mqef_pkg::REQ_PUSH,      1'b1, 64'hA5A5_A5A5_A5A5_A5A5);
        issue(mqef_pkg::REQ_REARM,     1'b1, '1);
        issue(mqef_pkg::REQ_PUSH,      1'b1, 64'h5A5A_5A5A_5A5A_5A5A);
        issue(mqef_pkg::REQ_POP,       1'b0, '1);
        issue(mqef_pkg::REQ_POP,       1'b0, '0);
        issue(mqef_pkg::REQ_POP,       1'b0, '0);
        issue(mqef_pkg::REQ_DEV_RESET, 1'b1, '0);
        issue(mqef_pkg::REQ_POP,       1'b1, '0);
        issue(mqef_pkg::REQ_PUSH,      1'b0, rand_word());
        issue(mqef_pkg::REQ_PUSH,      1'b1, rand_word());
        issue(mqef_pkg::REQ_REARM,     1'b0, '0);
        issue(mqef_pkg::REQ_DEV_RESET, 1'b0, '0);
        issue(mqef_pkg::REQ_DEV_RESET, 1'b0, '0);
        issue(mqef_pkg::REQ_POP,       1'b1, '0);
        issue(mqef_pkg::REQ_DEV_RESET, 1'b1, '0);
        issue(mqef_pkg::REQ_REARM,     1'b0, '1);

        // fill one ring past full, so pushes get dropped, with a little noise
        dev    = 1'($urandom_range(0, 1));
        pushed = 0;
        while (pushed < QUEUE_DEPTH + 6) begin
            if (pushed % 128 == 0)
                idle_on <= ($urandom_range(0, 2) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 94) begin
                issue(mqef_pkg::REQ_PUSH, dev, rand_word());
                pushed++;
            end else if (pick < 97) begin
                issue(mqef_pkg::REQ_PUSH, ~dev, rand_word());
            end else if (pick < 99) begin
                issue(mqef_pkg::REQ_REARM, dev, rand_word());
            end else begin
                issue(mqef_pkg::REQ_POP, ~dev, rand_word());
            end
        end

        // drain part of it so later pushes wrap the write slot
        idle_on <= 1'b1;
        for (int k = 0; k < 200; k++) begin
            if ($urandom_range(0, 19) == 0)
                issue(mqef_pkg::REQ_REARM, dev, rand_word());
            else
                issue(mqef_pkg::REQ_POP, dev, rand_word());
        end

        run_mix(1400, 1'b1);
        run_mix(1550, 1'b0);

        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (due_count == 0);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && due_count == 0)
            $display("multi_queue_event_fifo_with_wake_gate test passed");
        else
            $display("multi_queue_event_fifo_with_wake_gate test failed");
        $finish;
    end

endmodule
